### hw/rtl/tpo_pkg.sv
// tpo_pkg: shared types and constants of the tapered polyline outline block
// no dependencies

package tpo_pkg;

    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TAPER_SCALE = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PATH_LENGTH = 2'd2;

    localparam logic [31:0] HALF_WIDTH_RST  = 32'd65536;
    localparam logic [15:0] TAPER_SCALE_RST = 16'd0;
    localparam logic [15:0] PATH_LENGTH_RST = 16'd1024;

    localparam int          TAPER_WIDTH = 15;
    localparam logic [14:0] TAPER_ONE   = 15'd16384;

    typedef struct packed {
        logic lone;
        logic fin;
    } t_job_flags;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NORM,
        B_SQA,
        B_SQB,
        B_SQRT,
        B_DIV,
        B_WAITT,
        B_AMP,
        B_MULX,
        B_MULY,
        B_EMIT1,
        B_EMIT2
    } t_bstate;

endpackage

### hw/rtl/tpo_front.sv
// tpo_front: accepts path points, keeps the previous point and its index
// and builds one segment job per result group; uses tpo_pkg

module tpo_front #(
    parameter int CW = 32,
    parameter int IW = 16,
    parameter int JW = 6 * CW + IW + 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [CW-1:0] i_x,
    input  logic [CW-1:0] i_y,
    input  logic          i_fin,
    input  logic          i_full,
    output logic          o_push,
    output logic [JW-1:0] o_job
);

    logic [CW-1:0] r_prev_x;
    logic [CW-1:0] r_prev_y;
    logic          r_have;
    logic [IW-1:0] r_cnt;
    logic          accept;
    logic [CW:0]   dx;
    logic [CW:0]   dy;
    tpo_pkg::t_job_flags flags;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (r_have || i_fin);
    assign dx      = {i_x[CW-1], i_x} - {r_prev_x[CW-1], r_prev_x};
    assign dy      = {i_y[CW-1], i_y} - {r_prev_y[CW-1], r_prev_y};

    always_comb begin
        flags.lone = !r_have;
        flags.fin  = i_fin;
        if (r_have) begin
            o_job = {r_prev_x, r_prev_y, i_x, i_y, dx, dy, r_cnt, flags};
        end else begin
            o_job = {i_x, i_y, i_x, i_y, {(CW+1){1'b0}}, {(CW+1){1'b0}},
                     {IW{1'b0}}, flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_cnt    <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (accept) begin
            if (!r_have) begin
                r_cnt <= '0;
                if (!i_fin) begin
                    r_prev_x <= i_x;
                    r_prev_y <= i_y;
                    r_have   <= 1'b1;
                end
            end else begin
                r_prev_x <= i_x;
                r_prev_y <= i_y;
                if (i_fin) begin
                    r_have <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/tpo_queue.sv
// tpo_queue: two-entry job queue between front and back
// no dependencies

module tpo_queue #(
    parameter int JW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [JW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [JW-1:0] o_data
);

    logic [JW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;

    assign o_full  = r_count[1];
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### hw/rtl/tpo_back.sv
// tpo_back: normalizes a segment, takes length by square root, divides for
// the unit normal and the taper and drives the output register; uses tpo_pkg

module tpo_back #(
    parameter int CW = 32,
    parameter int IW = 16,
    parameter int JW = 6 * CW + IW + 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_qvalid,
    input  logic [JW-1:0] i_job,
    output logic          o_pop,
    input  logic [31:0]   i_half_width,
    input  logic [15:0]   i_taper_scale,
    input  logic [15:0]   i_path_length,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [CW-1:0] o_left_x,
    output logic [CW-1:0] o_left_y,
    output logic [CW-1:0] o_right_x,
    output logic [CW-1:0] o_right_y,
    output logic [IW-1:0] o_vertex_index,
    output logic          o_zero_segment,
    output logic          o_last_vertex
);

    localparam int AW  = (CW + 1 > 31) ? CW + 1 : 31;
    localparam int PW  = 16 + IW;
    localparam int TCW = $clog2(PW);
    localparam int SW  = ((CW > 34) ? CW : 34) + 2;
    localparam int TW  = tpo_pkg::TAPER_WIDTH;

    tpo_pkg::t_bstate r_state, n_state;

    logic [CW-1:0] r_px, r_py, r_cx, r_cy;
    logic [CW:0]   r_dx, r_dy;
    logic [IW-1:0] r_idx;
    logic          r_lone, r_fin, r_zero;
    logic [AW-1:0] r_a, r_b;
    logic [61:0]   r_s;
    logic [33:0]   r_rem;
    logic [30:0]   r_root;
    logic [4:0]    r_cnt;
    logic [31:0]   r_rx, r_ry;
    logic [30:0]   r_ux, r_uy;
    logic [32:0]   r_amp;
    logic [SW-1:0] r_ox, r_oy;

    logic          r_tbusy;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_tq;
    logic [16:0]   r_trem;
    logic [TCW-1:0] r_tcnt;

    logic          r_ovalid;
    logic          load_out;
    logic          start;

    logic [CW-1:0] j_px, j_py, j_cx, j_cy;
    logic [CW:0]   j_dx, j_dy;
    logic [IW-1:0] j_idx;
    tpo_pkg::t_job_flags j_flags;
    logic [CW:0]   j_ax, j_ay;
    logic          j_zero;

    logic [AW-1:0] m;
    logic          in_range;
    logic [33:0]   sq_rem;
    logic [33:0]   sq_t;
    logic [31:0]   dx_rem, dy_rem;
    logic          div_bit;
    logic [15:0]   den;
    logic [16:0]   t_rem;
    logic [TW-1:0] taper;
    logic [46:0]   amp_full;
    logic [63:0]   mul_full;
    logic [32:0]   mag;

    assign {j_px, j_py, j_cx, j_cy, j_dx, j_dy, j_idx, j_flags} = i_job;
    assign j_ax   = j_dx[CW] ? -j_dx : j_dx;
    assign j_ay   = j_dy[CW] ? -j_dy : j_dy;
    assign j_zero = j_flags.lone || (j_dx == '0 && j_dy == '0);

    assign m        = (r_a > r_b) ? r_a : r_b;
    assign in_range = (m[AW-1:30] == '0) && m[29];

    assign load_out = !r_ovalid || i_ready;
    assign o_pop    = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpo_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        start   = 1'b0;
        unique case (r_state)
            tpo_pkg::B_IDLE: begin
                if (i_qvalid && !r_tbusy) begin
                    start   = 1'b1;
                    n_state = j_zero ? tpo_pkg::B_EMIT1 : tpo_pkg::B_NORM;
                end
            end
            tpo_pkg::B_NORM:  if (in_range) n_state = tpo_pkg::B_SQA;
            tpo_pkg::B_SQA:   n_state = tpo_pkg::B_SQB;
            tpo_pkg::B_SQB:   n_state = tpo_pkg::B_SQRT;
            tpo_pkg::B_SQRT:  if (r_cnt == '0) n_state = tpo_pkg::B_DIV;
            tpo_pkg::B_DIV:   if (r_cnt == '0) n_state = tpo_pkg::B_WAITT;
            tpo_pkg::B_WAITT: if (!r_tbusy) n_state = tpo_pkg::B_AMP;
            tpo_pkg::B_AMP:   n_state = tpo_pkg::B_MULX;
            tpo_pkg::B_MULX:  n_state = tpo_pkg::B_MULY;
            tpo_pkg::B_MULY:  n_state = tpo_pkg::B_EMIT1;
            tpo_pkg::B_EMIT1: begin
                if (load_out) begin
                    n_state = (r_fin && !r_lone) ? tpo_pkg::B_EMIT2 : tpo_pkg::B_IDLE;
                end
            end
            tpo_pkg::B_EMIT2: if (load_out) n_state = tpo_pkg::B_IDLE;
            default:          n_state = tpo_pkg::B_IDLE;
        endcase
    end

    // square root and divider steps
    assign sq_rem  = {r_rem[31:0], r_s[{r_cnt, 1'b1}], r_s[{r_cnt, 1'b0}]};
    assign sq_t    = {1'b0, r_root, 2'b01};
    assign div_bit = (r_cnt == 5'd30);
    assign dx_rem  = {r_rx[30:0], div_bit & r_b[0]};
    assign dy_rem  = {r_ry[30:0], div_bit & r_a[0]};

    assign taper    = (r_tq >= PW'(tpo_pkg::TAPER_ONE)) ? '0
                    : TW'(tpo_pkg::TAPER_ONE - r_tq[TW-1:0]);
    assign amp_full = i_half_width * taper;
    assign mul_full = r_amp * ((r_state == tpo_pkg::B_MULX) ? r_ux : r_uy);
    assign mag      = mul_full[62:30];

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_px   <= j_px;
            r_py   <= j_py;
            r_cx   <= j_cx;
            r_cy   <= j_cy;
            r_dx   <= j_dx;
            r_dy   <= j_dy;
            r_idx  <= j_idx;
            r_lone <= j_flags.lone;
            r_fin  <= j_flags.fin;
            r_zero <= j_zero;
            r_a    <= AW'(j_ax);
            r_b    <= AW'(j_ay);
            r_ox   <= '0;
            r_oy   <= '0;
        end
        unique case (r_state)
            tpo_pkg::B_NORM: begin
                if (m[AW-1:29] == '0) begin
                    r_a <= r_a << 1;
                    r_b <= r_b << 1;
                end else if (!in_range) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                end
            end
            tpo_pkg::B_SQA: r_s <= 62'(r_a[29:0] * r_a[29:0]);
            tpo_pkg::B_SQB: begin
                r_s    <= r_s + 62'(r_b[29:0] * r_b[29:0]);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'd30;
            end
            tpo_pkg::B_SQRT: begin
                if (sq_rem >= sq_t) begin
                    r_rem  <= sq_rem - sq_t;
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem;
                    r_root <= {r_root[29:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_cnt <= 5'd30;
                    r_rx  <= {2'b00, r_b[29:0]} >> 1;
                    r_ry  <= {2'b00, r_a[29:0]} >> 1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            tpo_pkg::B_DIV: begin
                if (dx_rem >= {1'b0, r_root}) begin
                    r_rx <= dx_rem - {1'b0, r_root};
                    r_ux <= {r_ux[29:0], 1'b1};
                end else begin
                    r_rx <= dx_rem;
                    r_ux <= {r_ux[29:0], 1'b0};
                end
                if (dy_rem >= {1'b0, r_root}) begin
                    r_ry <= dy_rem - {1'b0, r_root};
                    r_uy <= {r_uy[29:0], 1'b1};
                end else begin
                    r_ry <= dy_rem;
                    r_uy <= {r_uy[29:0], 1'b0};
                end
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            tpo_pkg::B_AMP:  r_amp <= amp_full[46:14];
            tpo_pkg::B_MULX: r_ox <= r_dy[CW] ? -SW'(mag) : SW'(mag);
            tpo_pkg::B_MULY: r_oy <= r_dx[CW] ? -SW'(mag) : SW'(mag);
            default: ;
        endcase
    end

    // taper divider runs beside the segment datapath
    assign den   = (i_path_length == '0) ? 16'd1 : i_path_length;
    assign t_rem = {r_trem[15:0], r_prod[r_tcnt]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbusy <= 1'b0;
        end else if (start) begin
            r_tbusy <= 1'b1;
            r_prod  <= i_taper_scale * j_idx;
            r_tq    <= '0;
            r_trem  <= '0;
            r_tcnt  <= TCW'(PW - 1);
        end else if (r_tbusy) begin
            if (t_rem >= {1'b0, den}) begin
                r_trem <= t_rem - {1'b0, den};
                r_tq   <= {r_tq[PW-2:0], 1'b1};
            end else begin
                r_trem <= t_rem;
                r_tq   <= {r_tq[PW-2:0], 1'b0};
            end
            if (r_tcnt == '0) begin
                r_tbusy <= 1'b0;
            end else begin
                r_tcnt <= r_tcnt - 1'b1;
            end
        end
    end

    function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
        logic signed [SW-1:0] sv;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        sv = v;
        hi = SW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (sv > hi) begin
            sat = hi[CW-1:0];
        end else if (sv < lo) begin
            sat = lo[CW-1:0];
        end else begin
            sat = sv[CW-1:0];
        end
    endfunction

    logic [SW-1:0] bx, by;
    logic          second;
    assign second = (r_state == tpo_pkg::B_EMIT2);
    assign bx = second ? SW'($signed(r_cx)) : SW'($signed(r_px));
    assign by = second ? SW'($signed(r_cy)) : SW'($signed(r_py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == tpo_pkg::B_EMIT1 || second) && load_out) begin
            r_ovalid       <= 1'b1;
            o_left_x       <= sat(bx + r_ox);
            o_left_y       <= sat(by - r_oy);
            o_right_x      <= sat(bx - r_ox);
            o_right_y      <= sat(by + r_oy);
            o_vertex_index <= second ? r_idx + 1'b1 : r_idx;
            o_zero_segment <= r_zero;
            o_last_vertex  <= second || r_lone;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;

    a_emit2_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpo_pkg::B_EMIT2 |-> r_fin && !r_lone)
        else $error("second vertex pair without a final segment");

    a_len_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpo_pkg::B_DIV |-> r_root[30:29] != 2'b00)
        else $error("segment length not normalized");

    a_taper_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpo_pkg::B_AMP |-> !r_tbusy)
        else $error("taper used before divider finished");

endmodule

### hw/rtl/tapered_polyline_outline.sv
// tapered_polyline_outline: top level, configuration registers and the
// front, queue and back parts; uses tpo_pkg, tpo_front, tpo_queue, tpo_back
//
// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_ready   i_point_x, i_point_y, i_final_point
// output   out        o_out_valid / i_out_ready left/right x/y, index, flags
// config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// a segment goes through the back part: start, normalization shifts, squaring,
// 31 square root and 31 divider steps, taper wait, multiplies and the output load;
// a zero segment goes straight to the output load, but the next job waits for the
// 32-step taper divider that it started; a final point after another point adds a
// second output; synchronous active-low reset clears the control and config state
// the two-entry queue lets the front take points while the output stalls

module tapered_polyline_outline #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COORD_WIDTH-1:0]   i_point_x,
    input  logic [COORD_WIDTH-1:0]   i_point_y,
    input  logic                     i_final_point,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [COORD_WIDTH-1:0]   o_left_x,
    output logic [COORD_WIDTH-1:0]   o_left_y,
    output logic [COORD_WIDTH-1:0]   o_right_x,
    output logic [COORD_WIDTH-1:0]   o_right_y,
    output logic [INDEX_WIDTH-1:0]   o_vertex_index,
    output logic                     o_zero_segment,
    output logic                     o_last_vertex,
    input  logic                     i_cfg_we,
    input  logic [tpo_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [31:0]              i_cfg_data
);

    localparam int JW = 6 * COORD_WIDTH + INDEX_WIDTH + 4;

    logic [31:0] r_half_width;
    logic [15:0] r_taper_scale;
    logic [15:0] r_path_length;

    logic          push, full, pop, qvalid;
    logic [JW-1:0] job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= tpo_pkg::HALF_WIDTH_RST;
            r_taper_scale <= tpo_pkg::TAPER_SCALE_RST;
            r_path_length <= tpo_pkg::PATH_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpo_pkg::REG_HALF_WIDTH:  r_half_width  <= i_cfg_data;
                tpo_pkg::REG_TAPER_SCALE: r_taper_scale <= i_cfg_data[15:0];
                tpo_pkg::REG_PATH_LENGTH: r_path_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tpo_front #(.CW(COORD_WIDTH), .IW(INDEX_WIDTH), .JW(JW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_fin   (i_final_point),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    tpo_queue #(.JW(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_data  (job_out)
    );

    tpo_back #(.CW(COORD_WIDTH), .IW(INDEX_WIDTH), .JW(JW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qvalid       (qvalid),
        .i_job          (job_out),
        .o_pop          (pop),
        .i_half_width   (r_half_width),
        .i_taper_scale  (r_taper_scale),
        .i_path_length  (r_path_length),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_left_x       (o_left_x),
        .o_left_y       (o_left_y),
        .o_right_x      (o_right_x),
        .o_right_y      (o_right_y),
        .o_vertex_index (o_vertex_index),
        .o_zero_segment (o_zero_segment),
        .o_last_vertex  (o_last_vertex)
    );

endmodule
